FILE: rtl/vga_pkg.sv
// Shared types, constants and helper functions of the voxel grid accumulator.
`default_nettype none
package vga_pkg;

   localparam int EDGE_BITS  = 3;
   localparam int MAX_CHUNKS = 64;

   localparam int COORD_BITS  = 8;
   localparam int CFG_BITS    = 6;
   localparam int CSR_IDX_BITS = 2;
   localparam int CNT_W       = 32;
   localparam int RAY_W       = 32;
   localparam int SUM_W       = 48;
   localparam int FRAC_BITS   = 16;

   localparam int CELL_BITS   = 3 * EDGE_BITS;
   localparam int CHUNK_BITS  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int ADDR_BITS   = CHUNK_BITS + CELL_BITS;
   localparam int CELLS       = MAX_CHUNKS << CELL_BITS;
   localparam int CCB         = COORD_BITS - EDGE_BITS;
   localparam int YTERM_BITS  = CCB + CFG_BITS;
   localparam int XY_BITS     = 2 * CFG_BITS;
   localparam int CHSUM_BITS  = CCB + XY_BITS + 1;

   localparam int DIV_W       = SUM_W + RAY_W;
   localparam int DIVISOR_W   = CNT_W + 1;
   localparam int STEP_W      = $clog2(DIV_W + 1);
   localparam int MEAN_STEPS  = SUM_W;
   localparam int VAR_STEPS   = DIV_W;
   localparam int HALF_W      = SUM_W / 2;
   localparam int PROD_W      = 2 * SUM_W;
   localparam int DELTA_W     = SUM_W + 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHUNKS_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHUNKS_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHUNKS_Z = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VAR_EN   = 2'd3;

   localparam logic [1:0] CMD_ADD_HIT  = 2'd0;
   localparam logic [1:0] CMD_ADD_LEN  = 2'd1;
   localparam logic [1:0] CMD_ADD_VAR  = 2'd2;

   typedef struct packed {
      logic [1:0]            command;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
      logic [COORD_BITS-1:0] coord_z;
      logic [RAY_W-1:0]      ray_length;
      logic                  is_hit;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] traversal_count;
      logic [SUM_W-1:0] length_sum;
      logic [SUM_W-1:0] hit_length_sum;
      logic [SUM_W-1:0] variance_sum;
      logic             out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] traversal_count;
      logic [SUM_W-1:0] length_sum;
      logic [SUM_W-1:0] hit_length_sum;
      logic [SUM_W-1:0] variance_sum;
   } cell_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_W-1:0]    steps;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ADDR1, ST_ADDR2, ST_FETCH, ST_READ, ST_DIV_MEAN,
      ST_DELTA1, ST_NEW_MEAN, ST_DELTA2, ST_MUL, ST_PROD_DONE, ST_DIV_VAR,
      ST_UPDATE, ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/voxel_grid_accumulator.sv
// Top level of the chunked voxel grid accumulator with Welford variance update.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | req_valid, req_ready, req_data          | in
//  response | rsp_valid, rsp_ready, rsp_data          | out
//  csr      | csr_write_enable, csr_index, csr_write_data | in
//
// One beat in flight at a time. Commands 0, 1, 3 and command 2 without a variance
// update go from accept to the next accept through address math, one read and one
// write; out-of-range beats skip the read and the write. A variance update adds three
// passes of the bit-serial divider (48 + 48 + 80 steps), four multiply steps and the
// setup states ST_DELTA1, ST_DELTA2 and ST_PROD_DONE.
// After reset a clearing pass writes all CELLS entries, one per cycle (32768 entries
// at the default size), with req_ready low; csr writes are taken meanwhile.
// A finished result waits in the output register while the next beat is accepted.
`default_nettype none
module voxel_grid_accumulator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire vga_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output vga_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_write_enable,
   input  wire logic [vga_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [vga_pkg::CFG_BITS-1:0]     csr_write_data
);
   import vga_pkg::*;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [CFG_BITS-1:0]  cax_ff, cay_ff, caz_ff;
   logic                 var_en_ff;
   req_type              req_ff;
   logic [XY_BITS-1:0]   xy_prod_ff;
   logic [YTERM_BITS-1:0] y_term_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic                 oor_ff;
   cell_type             cell_ff;
   logic [SUM_W-1:0]     mean_ff;
   logic                 neg1_ff;
   logic [SUM_W-1:0]     abs1_ff;
   logic [DELTA_W-1:0]   nmean_ff;
   logic [SUM_W-1:0]     abs2_ff;
   logic [PROD_W-1:0]    acc_ff;
   logic [1:0]           mul_cnt_ff;
   logic [SUM_W-1:0]     term_ff;
   logic                 var_do_ff;
   rsp_type              res_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   cell_type             rd_cell;
   cell_type             new_cell;
   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_waddr;
   cell_type             mem_wdata;
   div_req_type          div_req;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;
   logic                 var_path;
   logic                 rsp_load;
   logic [CCB-1:0]       cx, cy, cz;
   logic [CHSUM_BITS-1:0] chunk;
   logic                 range_bad;
   logic [CELL_BITS-1:0] local_idx;
   logic [DELTA_W-1:0]   d1, d2;
   logic [SUM_W-1:0]     abs1_c, abs2_c;
   logic [HALF_W-1:0]    a_part, b_part;
   logic [SUM_W-1:0]     pp;
   logic [PROD_W-1:0]    pp_shift;

   vga_cell_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (addr_ff),
      .rd_data (rd_cell)
   );

   vga_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // address split
   always_comb begin
      cx = req_ff.coord_x[COORD_BITS-1:EDGE_BITS];
      cy = req_ff.coord_y[COORD_BITS-1:EDGE_BITS];
      cz = req_ff.coord_z[COORD_BITS-1:EDGE_BITS];
      chunk = CHSUM_BITS'(cx) + CHSUM_BITS'(y_term_ff) + CHSUM_BITS'(cz) * CHSUM_BITS'(xy_prod_ff);
      range_bad = (CHSUM_BITS'(cx) >= CHSUM_BITS'(cax_ff)) ||
                  (CHSUM_BITS'(cy) >= CHSUM_BITS'(cay_ff)) ||
                  (CHSUM_BITS'(cz) >= CHSUM_BITS'(caz_ff)) ||
                  (chunk >= CHSUM_BITS'(MAX_CHUNKS));
      local_idx = {req_ff.coord_z[EDGE_BITS-1:0], req_ff.coord_y[EDGE_BITS-1:0],
                   req_ff.coord_x[EDGE_BITS-1:0]};
   end

   // datapath helpers
   always_comb begin
      var_path = (req_ff.command == CMD_ADD_VAR) && var_en_ff &&
                 (rd_cell.traversal_count >= CNT_W'(2));
      d1     = DELTA_W'(req_ff.ray_length) - {1'b0, mean_ff};
      abs1_c = d1[DELTA_W-1] ? SUM_W'(~d1 + DELTA_W'(1)) : d1[SUM_W-1:0];
      d2     = DELTA_W'(req_ff.ray_length) - nmean_ff;
      abs2_c = d2[DELTA_W-1] ? SUM_W'(~d2 + DELTA_W'(1)) : d2[SUM_W-1:0];
      a_part = mul_cnt_ff[1] ? abs1_ff[SUM_W-1:HALF_W] : abs1_ff[HALF_W-1:0];
      b_part = mul_cnt_ff[0] ? abs2_ff[SUM_W-1:HALF_W] : abs2_ff[HALF_W-1:0];
      pp     = SUM_W'(a_part) * SUM_W'(b_part);
      case (mul_cnt_ff)
         2'd0:    pp_shift = PROD_W'(pp);
         2'd3:    pp_shift = PROD_W'(pp) << (2 * HALF_W);
         default: pp_shift = PROD_W'(pp) << HALF_W;
      endcase
   end

   // cell update
   always_comb begin
      new_cell = cell_ff;
      case (req_ff.command)
         CMD_ADD_HIT: begin
            new_cell.hit_count = sat_inc32(cell_ff.hit_count);
         end
         CMD_ADD_LEN: begin
            new_cell.length_sum = sat_add48(cell_ff.length_sum, SUM_W'(req_ff.ray_length));
            if (req_ff.is_hit) begin
               new_cell.hit_length_sum = sat_add48(cell_ff.hit_length_sum,
                                                   SUM_W'(req_ff.ray_length));
            end
            new_cell.traversal_count = sat_inc32(cell_ff.traversal_count);
         end
         CMD_ADD_VAR: begin
            new_cell.length_sum = sat_add48(cell_ff.length_sum, SUM_W'(req_ff.ray_length));
            new_cell.traversal_count = sat_inc32(cell_ff.traversal_count);
            if (var_do_ff) begin
               new_cell.variance_sum = sat_add48(cell_ff.variance_sum, term_ff);
            end
         end
         default: new_cell = cell_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = new_cell;
      rsp_load  = 1'b0;
      div_req   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == ADDR_BITS'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_ADDR1;
            end
         end
         ST_ADDR1: state_in = ST_ADDR2;
         ST_ADDR2: state_in = ST_FETCH;
         ST_FETCH: begin
            mem_re   = !oor_ff;
            state_in = oor_ff ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            if (var_path) begin
               div_req.start    = 1'b1;
               div_req.steps    = STEP_W'(MEAN_STEPS);
               div_req.dividend = {rd_cell.length_sum, RAY_W'(0)};
               div_req.divisor  = DIVISOR_W'(rd_cell.traversal_count);
               state_in = ST_DIV_MEAN;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               state_in = ST_DELTA1;
            end
         end
         ST_DELTA1: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(MEAN_STEPS);
            div_req.dividend = {abs1_c, RAY_W'(0)};
            div_req.divisor  = DIVISOR_W'(cell_ff.traversal_count) + DIVISOR_W'(1);
            state_in = ST_NEW_MEAN;
         end
         ST_NEW_MEAN: begin
            if (div_done) begin
               state_in = ST_DELTA2;
            end
         end
         ST_DELTA2: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_cnt_ff == 2'd3) begin
               state_in = ST_PROD_DONE;
            end
         end
         ST_PROD_DONE: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(VAR_STEPS);
            div_req.dividend = acc_ff[PROD_W-1:FRAC_BITS];
            div_req.divisor  = DIVISOR_W'(cell_ff.traversal_count);
            state_in = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            mem_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cax_ff       <= CFG_BITS'(1);
         cay_ff       <= CFG_BITS'(1);
         caz_ff       <= CFG_BITS'(1);
         var_en_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CHUNKS_X: cax_ff    <= csr_write_data;
               CSR_CHUNKS_Y: cay_ff    <= csr_write_data;
               CSR_CHUNKS_Z: caz_ff    <= csr_write_data;
               CSR_VAR_EN:   var_en_ff <= csr_write_data[0];
               default:      var_en_ff <= var_en_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_ADDR1) begin
         xy_prod_ff <= XY_BITS'(cax_ff) * XY_BITS'(cay_ff);
         y_term_ff  <= YTERM_BITS'(cy) * YTERM_BITS'(cax_ff);
      end
      if (state_ff == ST_ADDR2) begin
         oor_ff  <= range_bad;
         addr_ff <= {chunk[CHUNK_BITS-1:0], local_idx};
      end
      if (state_ff == ST_FETCH) begin
         // all fields zero except the out-of-range flag
         res_ff <= {{(2 * CNT_W + 3 * SUM_W){1'b0}}, 1'b1};
      end
      if (state_ff == ST_READ) begin
         cell_ff   <= rd_cell;
         var_do_ff <= var_path;
      end
      if (state_ff == ST_DIV_MEAN && div_done) begin
         mean_ff <= div_quotient[SUM_W-1:0];
      end
      if (state_ff == ST_DELTA1) begin
         neg1_ff <= d1[DELTA_W-1];
         abs1_ff <= abs1_c;
      end
      if (state_ff == ST_NEW_MEAN && div_done) begin
         nmean_ff <= neg1_ff ? {1'b0, mean_ff} - {1'b0, div_quotient[SUM_W-1:0]}
                             : {1'b0, mean_ff} + {1'b0, div_quotient[SUM_W-1:0]};
      end
      if (state_ff == ST_DELTA2) begin
         abs2_ff    <= abs2_c;
         acc_ff     <= '0;
         mul_cnt_ff <= '0;
      end
      if (state_ff == ST_MUL) begin
         acc_ff     <= acc_ff + pp_shift;
         mul_cnt_ff <= mul_cnt_ff + 2'd1;
      end
      if (state_ff == ST_DIV_VAR && div_done) begin
         term_ff <= (|div_quotient[DIV_W-1:SUM_W]) ? {SUM_W{1'b1}}
                                                   : div_quotient[SUM_W-1:0];
      end
      if (state_ff == ST_UPDATE) begin
         res_ff.hit_count       <= new_cell.hit_count;
         res_ff.traversal_count <= new_cell.traversal_count;
         res_ff.length_sum      <= new_cell.length_sum;
         res_ff.hit_length_sum  <= new_cell.hit_length_sum;
         res_ff.variance_sum    <= new_cell.variance_sum;
         res_ff.out_of_range    <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/vga_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module vga_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire vga_pkg::div_req_type         div_req,
   output logic                              div_done,
   output logic [vga_pkg::DIV_W-1:0]         div_quotient
);
   import vga_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   partial;
   logic [DIVISOR_W+1:0] diff;

   always_comb begin
      partial = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = {1'b0, partial} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         dvd_in  = div_req.dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = diff[DIVISOR_W+1] ? partial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ~diff[DIVISOR_W+1]};
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/vga_cell_mem.sv
// Cell store: one write port, one read port with registered read data.
`default_nettype none
module vga_cell_mem (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [vga_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire vga_pkg::cell_type             wr_data,
   input  wire logic                          rd_en,
   input  wire logic [vga_pkg::ADDR_BITS-1:0] rd_addr,
   output vga_pkg::cell_type                  rd_data
);
   import vga_pkg::*;

   cell_type mem [CELLS];
   cell_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

FILE: rtl/vga_checker.sv
// Port-level checks for the voxel grid accumulator, bound to the top level.
`default_nettype none
module vga_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire vga_pkg::rsp_type rsp_data
);
   import vga_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed while stalled");

   // one beat in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

   // out-of-range results carry no cell contents
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.hit_count == '0 && rsp_data.traversal_count == '0 &&
         rsp_data.length_sum == '0 && rsp_data.hit_length_sum == '0 &&
         rsp_data.variance_sum == '0)
      else $error("out-of-range result with nonzero fields");

   // reset empties the output and holds off requests at the start of the clearing pass
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind voxel_grid_accumulator vga_checker u_vga_checker (.*);
`default_nettype wire
